/* src/secmem_pkg.sv */
// ----------------------------------------------------------------------------
// secmem_pkg
// Shared types, codes and Hamming(13,8) SECDED helpers for the ECC byte memory.
// ----------------------------------------------------------------------------
package secmem_pkg;

  localparam int ADDR_W = 10;
  localparam int DATA_W = 8;
  localparam int CHK_W  = 5;
  localparam int HAM_W  = 4;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int SYN_W  = 4;
  localparam int WORD_W = DATA_W + CHK_W;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RAW   = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_PARITY = 2'd1;
  localparam logic [STAT_W-1:0] ST_DOUBLE = 2'd2;
  localparam logic [STAT_W-1:0] ST_SINGLE = 2'd3;

  // back-end operation codes
  localparam logic [1:0] OP_NOP   = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [CHK_W-1:0]  check;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // d1 is bit 7, d8 is bit 0; result bit3 p1 .. bit0 p4
  function automatic logic [HAM_W-1:0] hamming_bits(input logic [DATA_W-1:0] d);
    logic p1, p2, p3, p4;
    p1 = d[7] ^ d[6] ^ d[4] ^ d[3] ^ d[1];
    p2 = d[7] ^ d[5] ^ d[4] ^ d[2] ^ d[1];
    p3 = d[6] ^ d[5] ^ d[4] ^ d[0];
    p4 = d[3] ^ d[2] ^ d[1] ^ d[0];
    return {p1, p2, p3, p4};
  endfunction

  function automatic logic overall_parity(input logic [DATA_W-1:0] d,
                                          input logic [HAM_W-1:0]  h);
    return ^{d, h};
  endfunction

endpackage

/* src/secmem_if.sv */
// ----------------------------------------------------------------------------
// secmem_if
// Valid/ready channels of the ECC byte memory: request and result.
// ----------------------------------------------------------------------------
interface secmem_in_if import secmem_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] wdata;
  logic [CHK_W-1:0]  wcheck;

  modport source (output valid, output kind, output addr, output wdata, output wcheck,
                  input ready);
  modport sink (input valid, input kind, input addr, input wdata, input wcheck,
                output ready);
endinterface

interface secmem_out_if import secmem_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rdata;
  logic [STAT_W-1:0] status;
  logic [SYN_W-1:0]  syndrome;

  modport source (output valid, output rdata, output status, output syndrome,
                  input ready);
  modport sink (input valid, input rdata, input status, input syndrome,
                output ready);
endinterface

/* src/secmem_front.sv */
// ----------------------------------------------------------------------------
// secmem_front
// Accepts request items, range-checks the address, encodes writes.
// ----------------------------------------------------------------------------
module secmem_front import secmem_pkg::*; #(
  parameter int MEM_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  secmem_in_if.sink     in_chan,
  input  back_stat_t    back_stat,
  input  logic          q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  localparam int EXT_W = 17;
  localparam logic [EXT_W-1:0] DEPTH_X = EXT_W'(MEM_DEPTH);

  logic              in_range;
  logic [HAM_W-1:0]  ham;
  logic              seen_r;
  logic              seen_nxt;

  assign in_range = EXT_W'(in_chan.addr) < DEPTH_X;
  assign ham      = hamming_bits(in_chan.wdata);

  assign in_chan.ready = !q_full && !back_stat.clearing;
  assign q_push        = in_chan.valid && in_chan.ready;

  always_comb begin
    q_cmd.addr  = in_chan.addr;
    q_cmd.data  = in_chan.wdata;
    q_cmd.check = in_chan.wcheck;
    q_cmd.op    = OP_NOP;
    if (in_range) begin
      unique case (in_chan.kind)
        KIND_WRITE: begin
          q_cmd.op    = OP_STORE;
          q_cmd.check = {overall_parity(in_chan.wdata, ham), ham};
        end
        KIND_RAW:  q_cmd.op = OP_STORE;
        KIND_READ: q_cmd.op = OP_READ;
        default:   q_cmd.op = OP_NOP;
      endcase
    end
  end

  // tracks that at least one item has entered since reset
  assign seen_nxt = seen_r || q_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.clearing |-> !q_push) else $error("item entered during memory clear");
  a_clear_before_items: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> !back_stat.clearing) else $error("memory clear after items entered");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push) else $error("push into full queue");
`endif

endmodule

/* src/secmem_queue.sv */
// ----------------------------------------------------------------------------
// secmem_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module secmem_queue import secmem_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == 2'd2;
  assign pop_valid = cnt_r != 2'd0;
  assign pop_cmd   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* src/secmem_back.sv */
// ----------------------------------------------------------------------------
// secmem_back
// Runs commands against the protected memory, checks reads, holds the result.
// ----------------------------------------------------------------------------
module secmem_back import secmem_pkg::*; #(
  parameter int MEM_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  cmd_t          q_cmd,
  output logic          q_pop,
  output back_stat_t    back_stat,
  secmem_out_if.source  out_chan
);

  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(MEM_DEPTH - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [WORD_W-1:0] mem [MEM_DEPTH];

  logic [1:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [AW-1:0]     chk_idx_r, chk_idx_nxt;
  logic [WORD_W-1:0] rd_word_r;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_rdata_r, out_rdata_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [SYN_W-1:0]  out_syn_r, out_syn_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [WORD_W-1:0] mem_wd;
  logic              mem_re;
  logic [AW-1:0]     cmd_idx;
  logic              out_free;

  logic [DATA_W-1:0] rd_data;
  logic [CHK_W-1:0]  rd_check;
  logic [HAM_W-1:0]  diff;
  logic [SYN_W-1:0]  syn;
  logic              pw_new;
  logic              pw_bad;

  assign cmd_idx  = AW'(q_cmd.addr);
  assign out_free = !out_valid_r || out_chan.ready;

  // syndrome is the check difference with its bits reversed (C1 as lsb)
  assign rd_data  = rd_word_r[WORD_W-1:CHK_W];
  assign rd_check = rd_word_r[CHK_W-1:0];
  assign diff     = hamming_bits(rd_data) ^ rd_check[HAM_W-1:0];
  assign syn      = {diff[0], diff[1], diff[2], diff[3]};
  assign pw_new   = overall_parity(rd_data, rd_check[HAM_W-1:0]);
  assign pw_bad   = pw_new != rd_check[CHK_W-1];

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    chk_idx_nxt    = chk_idx_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_rdata_nxt  = out_rdata_r;
    out_status_nxt = out_status_r;
    out_syn_nxt    = out_syn_r;
    mem_we         = 1'b0;
    mem_wa         = clr_idx_r;
    mem_wd         = '0;
    mem_re         = 1'b0;
    q_pop          = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            OP_STORE: begin
              mem_we         = 1'b1;
              mem_wa         = cmd_idx;
              mem_wd         = {q_cmd.data, q_cmd.check};
              out_valid_nxt  = 1'b1;
              out_rdata_nxt  = '0;
              out_status_nxt = ST_OK;
              out_syn_nxt    = '0;
            end
            OP_READ: begin
              mem_re      = 1'b1;
              chk_idx_nxt = cmd_idx;
              state_nxt   = S_CHECK;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_rdata_nxt  = '0;
              out_status_nxt = ST_OK;
              out_syn_nxt    = '0;
            end
          endcase
        end
      end
      S_CHECK: begin
        out_valid_nxt = 1'b1;
        out_rdata_nxt = rd_data;
        out_syn_nxt   = '0;
        state_nxt     = S_IDLE;
        if (syn == '0) begin
          out_status_nxt = pw_bad ? ST_PARITY : ST_OK;
          if (pw_bad) begin
            // repair the stored overall parity bit
            mem_we = 1'b1;
            mem_wa = chk_idx_r;
            mem_wd = {rd_data, pw_new, rd_check[HAM_W-1:0]};
          end
        end else if (!pw_bad) begin
          out_status_nxt = ST_DOUBLE;
        end else begin
          out_status_nxt = ST_SINGLE;
          out_syn_nxt    = syn;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_status_r <= out_status_nxt;
    out_syn_r    <= out_syn_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_word_r <= mem[cmd_idx];
    end
  end

  assign back_stat.clearing = state_r == S_CLEAR;

  assign out_chan.valid    = out_valid_r;
  assign out_chan.rdata    = out_rdata_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.syndrome = out_syn_r;

`ifndef NO_ASSERTIONS
  a_check_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> !out_valid_r) else $error("result slot busy during check");
  a_check_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |=> out_valid_r && state_r == S_IDLE)
    else $error("read check produced no item");
  a_read_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_cmd.op == OP_READ |=> state_r == S_CHECK)
    else $error("read pop did not enter check");
  a_pop_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid && out_free && state_r == S_IDLE)
    else $error("pop without free result slot");
`endif

endmodule

/* src/secmem_ecc_byte_memory_placeholder.sv */
// ----------------------------------------------------------------------------
// secmem_ecc_parity_repair_check
// Port-level result checker: status and syndrome fields stay consistent.
// ----------------------------------------------------------------------------
module secmem_ecc_parity_repair_check import secmem_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic [SYN_W-1:0]  out_syndrome
);

  logic single_err;

  assign single_err = out_status == ST_SINGLE;

`ifndef NO_ASSERTIONS
  a_syn_only_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !single_err |-> out_syndrome == '0)
    else $error("syndrome given without single-bit error");
  a_single_has_syn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && single_err |-> out_syndrome != '0)
    else $error("single-bit error with zero syndrome");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("stalled result changed");
`endif

endmodule

/* src/secded_ecc_byte_memory.sv */
// ----------------------------------------------------------------------------
// secded_ecc_byte_memory
// Byte memory protected by Hamming(13,8) SECDED check bits.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan (valid/ready) takes one item: kind, addr, wdata, wcheck.
//   kind write stores the byte with its four check bits and overall parity;
//   raw store writes wdata and wcheck unencoded; read checks the stored word.
//   out_chan gives one result item per request item, in order: rdata (the
//   stored byte on a read, uncorrected), status and syndrome. Writes, raw
//   stores, unused kinds and addresses at or beyond MEM_DEPTH give zeros.
//   A read with a good check bit pattern but a bad overall parity bit
//   rewrites that parity bit in memory.
//   A write result is registered when the back end pops its entry
//   from the queue; a read result follows the registered memory read
//   and the check state. Throughput: one write per cycle while out_chan
//   is ready; no item is popped during a read check. Reset: the back end
//   clears every word, one per cycle; in_chan.ready stays low meanwhile.
//   A stalled out_chan holds its item; the 2-entry queue then fills and
//   in_chan.ready drops.
// ----------------------------------------------------------------------------
module secded_ecc_byte_memory import secmem_pkg::*; #(
  parameter int MEM_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  secmem_in_if.sink     in_chan,
  secmem_out_if.source  out_chan
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  cmd_t       push_cmd;
  cmd_t       pop_cmd;
  back_stat_t back_stat;

  secmem_front #(.MEM_DEPTH(MEM_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .back_stat (back_stat),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  secmem_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (pop_cmd)
  );

  secmem_back #(.MEM_DEPTH(MEM_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .back_stat (back_stat),
    .out_chan  (out_chan)
  );

  secmem_ecc_parity_repair_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_status   (out_chan.status),
    .out_syndrome (out_chan.syndrome)
  );

endmodule
